// File: hdl/pss_pkg.sv
// Shared types and constants of the polygon scanline span engine.
// Used by the controller, the datapath and the top level; depends on nothing.

package pss_pkg;

    // Width of a vertex coordinate and of a scanline row.
    localparam int COORD_W = 16;
    // Width of a span column on the output side.
    localparam int SPAN_W = 12;
    // Width of the frame size registers.
    localparam int FRAME_W = 13;

    // Input command codes.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers and the frame size limit.
    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [FRAME_W-1:0] FRAME_LIMIT      = 13'd4096;

    // Bounding box values of an empty polygon.
    localparam logic signed [COORD_W-1:0] BOX_LOW_INIT  = 16'sd10000;
    localparam logic signed [COORD_W-1:0] BOX_HIGH_INIT = -16'sd10000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;      // reset polygon, box and overflow flag
        logic add;        // store the input vertex and widen the box
        logic setup;      // latch the query row and start the span
        logic rd_zero;    // read vertex 0 instead of the next vertex
        logic load0;      // take the read vertex as the current vertex
        logic idx_step;   // move to the next edge
        logic edge_eval;  // evaluate the edge from current to read vertex
        logic div_start;  // start the divider on the current edge
        logic mul;        // register quotient times edge width
        logic acc;        // round, offset and merge the crossing into the span
        logic out_load;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go;           // query row inside the box clamped to the frame, polygon not empty
        logic last_edge;    // current edge is the closing edge
        logic edge_active;  // current edge spans the query row
        logic edge_flat;    // current edge is horizontal
        logic div_done;     // divider quotient is ready
        logic out_free;     // result register can take a new item
    } t_status;

endpackage

// File: hdl/pss_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Used by the datapath for the edge intersection; depends on no package.

module pss_div #(
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [15:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_dvd;
    logic [15:0]     r_rem;
    logic [15:0]     r_dvs;

    logic [16:0] w_shift;
    logic        w_ge;
    logic [16:0] w_sub;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        w_shift = {r_rem, r_dvd[DW-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_sub   = w_shift - {1'b0, r_dvs};
    end

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and shifting dividend; quotient bits fill the dividend from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[15:0] : w_shift[15:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// File: hdl/pss_dp.sv
// Datapath of the span engine: vertex memory, bounding box, edge arithmetic,
// span registers and result register. Depends on pss_pkg and pss_div.

module pss_dp #(
    parameter int MAX_VERTICES = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pss_pkg::t_cmd                       i_cmd,
    output pss_pkg::t_status                    o_status,
    input  logic signed [pss_pkg::COORD_W-1:0]  i_in_x,
    input  logic signed [pss_pkg::COORD_W-1:0]  i_in_y,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_index,
    input  logic [pss_pkg::FRAME_W-1:0]         i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_span_valid,
    output logic signed [pss_pkg::COORD_W-1:0]  o_span_row,
    output logic [pss_pkg::SPAN_W-1:0]          o_span_start,
    output logic [pss_pkg::SPAN_W-1:0]          o_span_end,
    output logic                                o_vertex_dropped
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    // The shifted row offset, the quotient and the product all wrap at 32 bits.
    localparam int PW = 32;
    localparam logic [PW-1:0] ROUND =
        {{(PW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};

    // Configuration registers.
    logic [pss_pkg::FRAME_W-1:0] r_frame_w;
    logic [pss_pkg::FRAME_W-1:0] r_frame_h;

    // Polygon state.
    logic signed [15:0] mem_x [MAX_VERTICES];
    logic signed [15:0] mem_y [MAX_VERTICES];
    logic [CW-1:0]      r_count;
    logic               r_overflow;
    logic signed [15:0] r_box_min_x;
    logic signed [15:0] r_box_min_y;
    logic signed [15:0] r_box_max_x;
    logic signed [15:0] r_box_max_y;

    // Query state.
    logic signed [15:0] r_qy;
    logic               r_go;
    logic [AW-1:0]      r_idx;
    logic signed [15:0] r_rd_x;
    logic signed [15:0] r_rd_y;
    logic signed [15:0] r_cur_x;
    logic signed [15:0] r_cur_y;
    logic signed [15:0] r_e_tx;
    logic signed [16:0] r_e_dx;
    logic [PW-1:0]      r_prod;
    logic signed [15:0] r_start;
    logic signed [15:0] r_end;

    // Result register.
    logic               r_out_valid;
    logic               r_out_span_valid;
    logic signed [15:0] r_out_row;
    logic [11:0]        r_out_start;
    logic [11:0]        r_out_end;
    logic               r_out_dropped;

    logic               w_full;
    logic [CW-1:0]      w_idx_inc;
    logic               w_last;
    logic [AW-1:0]      w_rd_addr;
    logic [12:0]        w_fw;
    logic [12:0]        w_fh;
    logic signed [16:0] w_lo;
    logic signed [16:0] w_hi;
    logic signed [16:0] w_qy;
    logic               w_in_range;
    logic               w_swap;
    logic signed [15:0] w_tx;
    logic signed [15:0] w_ty;
    logic signed [15:0] w_bx;
    logic signed [15:0] w_by;
    logic               w_active;
    logic               w_flat;
    logic signed [15:0] w_hmin;
    logic signed [15:0] w_hmax;
    logic signed [16:0] w_qdiff;
    logic signed [16:0] w_dy;
    logic [PW-1:0]      w_dividend;
    logic               w_div_done;
    logic [PW-1:0]      w_quot;
    logic [PW-1:0]      w_dx_ext;
    logic [PW-1:0]      w_p;
    logic signed [15:0] w_ix;
    logic signed [16:0] w_end17;
    logic signed [16:0] w_start17;
    logic signed [16:0] w_fw17;
    logic signed [16:0] w_end_c;
    logic signed [16:0] w_start_c;
    logic               w_span_ok;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= pss_pkg::FRAME_WIDTH_RST;
            r_frame_h <= pss_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pss_pkg::REG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                pss_pkg::REG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                default:                   r_frame_w <= r_frame_w;
            endcase
        end
    end

    // Edge index arithmetic; the closing edge wraps back to vertex 0.
    always_comb begin
        w_full    = (r_count == CW'(MAX_VERTICES));
        w_idx_inc = CW'(r_idx) + CW'(1);
        w_last    = (w_idx_inc == r_count);
        if (i_cmd.rd_zero || w_last) begin
            w_rd_addr = '0;
        end else begin
            w_rd_addr = w_idx_inc[AW-1:0];
        end
    end

    // Vertex memory: written by add, read one vertex per cycle during a query.
    always_ff @(posedge i_clk) begin
        if (i_cmd.add && !w_full) begin
            mem_x[r_count[AW-1:0]] <= i_in_x;
            mem_y[r_count[AW-1:0]] <= i_in_y;
        end
        r_rd_x <= mem_x[w_rd_addr];
        r_rd_y <= mem_y[w_rd_addr];
    end

    // Vertex count, bounding box and overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_box_min_x <= pss_pkg::BOX_LOW_INIT;
            r_box_min_y <= pss_pkg::BOX_LOW_INIT;
            r_box_max_x <= pss_pkg::BOX_HIGH_INIT;
            r_box_max_y <= pss_pkg::BOX_HIGH_INIT;
        end else if (i_cmd.add) begin
            if (w_full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
                if (i_in_x < r_box_min_x) r_box_min_x <= i_in_x;
                if (i_in_y < r_box_min_y) r_box_min_y <= i_in_y;
                if (i_in_x > r_box_max_x) r_box_max_x <= i_in_x;
                if (i_in_y > r_box_max_y) r_box_max_y <= i_in_y;
            end
        end
    end

    // Row range test against the box clamped to the frame.
    always_comb begin
        w_fh = (r_frame_h > pss_pkg::FRAME_LIMIT) ? pss_pkg::FRAME_LIMIT : r_frame_h;
        w_fw = (r_frame_w > pss_pkg::FRAME_LIMIT) ? pss_pkg::FRAME_LIMIT : r_frame_w;
        w_lo = (r_box_min_y < 16'sd0) ? 17'sd0 : 17'(r_box_min_y);
        w_hi = $signed({4'b0, w_fh}) - 17'sd1;
        if (17'(r_box_max_y) < w_hi) begin
            w_hi = 17'(r_box_max_y);
        end
        w_qy       = 17'(i_in_y);
        w_in_range = (w_qy >= w_lo) && (w_qy <= w_hi);
    end

    // Current edge, ordered so that the top endpoint has the smaller y.
    always_comb begin
        w_swap     = (r_rd_y < r_cur_y);
        w_tx       = w_swap ? r_rd_x : r_cur_x;
        w_ty       = w_swap ? r_rd_y : r_cur_y;
        w_bx       = w_swap ? r_cur_x : r_rd_x;
        w_by       = w_swap ? r_cur_y : r_rd_y;
        w_active   = (w_ty <= r_qy) && (w_by >= r_qy);
        w_flat     = (w_by == w_ty);
        w_hmin     = (w_bx < w_tx) ? w_bx : w_tx;
        w_hmax     = (w_bx < w_tx) ? w_tx : w_bx;
        w_qdiff    = 17'(r_qy) - 17'(w_ty);
        w_dy       = 17'(w_by) - 17'(w_ty);
        w_dividend = PW'({w_qdiff, {FRAC_BITS{1'b0}}});
    end

    pss_div #(
        .DW(PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_dy[15:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Rounded crossing: product, half-unit rounding, integer part plus top x.
    always_comb begin
        w_dx_ext = {{(PW - 17){r_e_dx[16]}}, r_e_dx};
        w_p      = r_prod + ROUND;
        w_ix     = $signed(16'(w_p[PW-1:FRAC_BITS]) + r_e_tx);
    end

    // Query sequencing registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_qy  <= i_in_y;
            r_go  <= w_in_range && (r_count != '0);
            r_idx <= '0;
        end else if (i_cmd.idx_step) begin
            r_idx <= w_idx_inc[AW-1:0];
        end
        if (i_cmd.load0 || i_cmd.edge_eval) begin
            r_cur_x <= r_rd_x;
            r_cur_y <= r_rd_y;
        end
        if (i_cmd.edge_eval) begin
            r_e_tx <= w_tx;
            r_e_dx <= 17'(w_bx) - 17'(w_tx);
        end
        if (i_cmd.mul) begin
            r_prod <= w_quot * w_dx_ext;
        end
    end

    // Span extremes: start from the box, widen by flat edges and crossings.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_start <= r_box_max_x;
            r_end   <= r_box_min_x;
        end else if (i_cmd.edge_eval && w_active && w_flat) begin
            if (r_start > w_hmin) r_start <= w_hmin;
            if (r_end < w_hmax)   r_end   <= w_hmax;
        end else if (i_cmd.acc) begin
            if (w_ix < r_start) r_start <= w_ix;
            if (w_ix > r_end)   r_end   <= w_ix;
        end
    end

    // Clip the span to the frame and decide whether it is empty.
    always_comb begin
        w_end17   = 17'(r_end);
        w_start17 = 17'(r_start);
        w_fw17    = $signed({4'b0, w_fw});
        w_end_c   = (w_end17 >= w_fw17) ? (w_fw17 - 17'sd1) : w_end17;
        w_start_c = (w_start17 < 17'sd0) ? 17'sd0 : w_start17;
        w_span_ok = r_go && (w_start_c <= w_end_c);
    end

    // Result register; it parts the controller from the output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_span_valid <= w_span_ok;
            r_out_row        <= r_qy;
            r_out_start      <= w_span_ok ? w_start_c[11:0] : 12'd0;
            r_out_end        <= w_span_ok ? w_end_c[11:0] : 12'd0;
            r_out_dropped    <= r_overflow;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.go          = r_go;
        o_status.last_edge   = w_last;
        o_status.edge_active = w_active;
        o_status.edge_flat   = w_flat;
        o_status.div_done    = w_div_done;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_span_valid     = r_out_span_valid;
    assign o_span_row       = r_out_row;
    assign o_span_start     = r_out_start;
    assign o_span_end       = r_out_end;
    assign o_vertex_dropped = r_out_dropped;

endmodule

// File: hdl/pss_ctrl.sv
// Controller of the span engine: accepts items and sequences the edge walk.
// Depends on pss_pkg for the command and status structs and command codes.

module pss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_op,
    output logic             o_in_ready,
    input  pss_pkg::t_status i_status,
    output pss_pkg::t_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_FETCH0 = 9'b000000010,
        S_LOAD0  = 9'b000000100,
        S_READ   = 9'b000001000,
        S_EDGE   = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_MUL    = 9'b001000000,
        S_ACC    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_op)
                        pss_pkg::CMD_CLEAR: o_cmd.clear = 1'b1;
                        pss_pkg::CMD_ADD:   o_cmd.add   = 1'b1;
                        pss_pkg::CMD_QUERY: begin
                            o_cmd.setup = 1'b1;
                            n_state     = S_FETCH0;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH0: begin
                o_cmd.rd_zero = 1'b1;
                n_state = i_status.go ? S_LOAD0 : S_DONE;
            end
            S_LOAD0: begin
                o_cmd.load0 = 1'b1;
                n_state     = S_READ;
            end
            S_READ: begin
                n_state = S_EDGE;
            end
            S_EDGE: begin
                o_cmd.edge_eval = 1'b1;
                if (i_status.edge_active && !i_status.edge_flat) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_status.last_edge) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (i_status.last_edge) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hdl/polygon_scanline_span_engine_unit.sv
// Polygon scanline span engine: vertex list, bounding box and span queries.
// Clear and add-vertex items give no result. A query walks the edges from vertex 0;
// a non-flat edge that crosses the row also runs the divider (32 divider steps), a
// multiply and an accumulate. A row outside the box skips the walk; the result may
// wait for the result register. One item is in work at a time. Synchronous reset
// empties the polygon and loads 640 x 480; the vertex memory needs no clearing pass.

module polygon_scanline_span_engine_unit #(
    parameter int MAX_VERTICES = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    // Result item stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] span_row, [27:16] span_start,
                                        // [39:28] span_end, [40] vertex_dropped, rest 0
    output logic [0:0]  m_axis_tuser,   // [0] span_valid
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    pss_pkg::t_cmd    w_cmd;
    pss_pkg::t_status w_status;
    logic             w_in_ready;
    logic             w_span_valid;
    logic [15:0]      w_span_row;
    logic [11:0]      w_span_start;
    logic [11:0]      w_span_end;
    logic             w_vertex_dropped;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pss_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_in_x           (s_axis_tdata[15:0]),
        .i_in_y           (s_axis_tdata[31:16]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_span_valid     (w_span_valid),
        .o_span_row       (w_span_row),
        .o_span_start     (w_span_start),
        .o_span_end       (w_span_end),
        .o_vertex_dropped (w_vertex_dropped)
    );

    // Configuration writes are always taken.
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_in_ready;

    // Pack the result item.
    assign m_axis_tdata = {7'd0, w_vertex_dropped, w_span_end, w_span_start, w_span_row};
    assign m_axis_tuser = w_span_valid;

endmodule

// File: tb/sv/polygon_scanline_span_engine_unit_tb.sv
// Self-checking testbench for polygon_scanline_span_engine_unit.
// Drives vertex and scanline items plus frame size writes, predicts every span with
// its own model of the edge walk, and depends on pss_pkg and the unit itself.

module polygon_scanline_span_engine_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES = 16;
    localparam int FRAC_BITS    = 16;

    // No such command exists; the unit must ignore it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Covers the worst query, in which every edge of a full polygon crosses the row.
    localparam int SETTLE_CYCLES  = 700;
    // Cycles in a row with no item moving on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [15:0] coord_x, [31:16] coord_y
    logic [1:0]  s_axis_tuser;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;   // [15:0] span_row, [27:16] span_start,
                                 // [39:28] span_end, [40] vertex_dropped
    logic [0:0]  m_axis_tuser;   // [0] span_valid
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;

    bit in_idle_en  = 1'b1;
    bit out_idle_en = 1'b1;
    int out_hold    = 0;
    int quiet_cycles = 0;

    // Span prediction and result checking.
    class t_span_scoreboard;
        typedef struct {
            logic        span_valid;
            logic [15:0] span_row;
            logic [11:0] span_start;
            logic [11:0] span_end;
            logic        vertex_dropped;
        } t_span_item;

        int vert_x[MAX_VERTICES];
        int vert_y[MAX_VERTICES];
        int vert_count;
        int box_x_lo, box_y_lo, box_x_hi, box_y_hi;
        bit dropped_flag;
        int frame_w, frame_h;
        t_span_item expected_spans[$];
        int mismatch_count;

        function new();
            frame_w = pss_pkg::FRAME_WIDTH_RST;
            frame_h = pss_pkg::FRAME_HEIGHT_RST;
            mismatch_count = 0;
            clear_polygon();
        endfunction

        function void clear_polygon();
            vert_count   = 0;
            box_x_lo     = pss_pkg::BOX_LOW_INIT;
            box_y_lo     = pss_pkg::BOX_LOW_INIT;
            box_x_hi     = pss_pkg::BOX_HIGH_INIT;
            box_y_hi     = pss_pkg::BOX_HIGH_INIT;
            dropped_flag = 1'b0;
        endfunction

        function void set_frame(logic idx, logic [12:0] val);
            if (idx == pss_pkg::REG_FRAME_WIDTH) begin
                frame_w = val;
            end else begin
                frame_h = val;
            end
        endfunction

        // Crossing column of a non-flat edge; the product wraps at 32 bits.
        function int cross_at(int ax, int ay, int bx, int by, int row);
            bit [31:0] dy, place, quo, width_u, prod, sum;
            dy      = by - ay;
            place   = row - ay;
            place   = place << FRAC_BITS;
            quo     = place / dy;
            width_u = bx - ax;
            prod    = quo * width_u + (32'd1 << (FRAC_BITS - 1));
            sum     = (prod >> FRAC_BITS) + ax;
            return int'($signed(sum[15:0]));
        endfunction

        // Called for every accepted input item.
        function void note_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y);
            int cx, cy, fw, fh, row_lo, row_hi, span_lo, span_hi;
            int ax, ay, bx, by, nxt, hit, t;
            t_span_item want;
            cx = int'($signed(x));
            cy = int'($signed(y));
            case (cmd)
                pss_pkg::CMD_CLEAR: begin
                    clear_polygon();
                end
                pss_pkg::CMD_ADD: begin
                    if (vert_count >= MAX_VERTICES) begin
                        dropped_flag = 1'b1;
                    end else begin
                        vert_x[vert_count] = cx;
                        vert_y[vert_count] = cy;
                        vert_count++;
                        if (cx < box_x_lo) box_x_lo = cx;
                        if (cy < box_y_lo) box_y_lo = cy;
                        if (cx > box_x_hi) box_x_hi = cx;
                        if (cy > box_y_hi) box_y_hi = cy;
                    end
                end
                pss_pkg::CMD_QUERY: begin
                    fw = (frame_w > pss_pkg::FRAME_LIMIT) ? pss_pkg::FRAME_LIMIT : frame_w;
                    fh = (frame_h > pss_pkg::FRAME_LIMIT) ? pss_pkg::FRAME_LIMIT : frame_h;
                    row_lo = (box_y_lo < 0) ? 0 : box_y_lo;
                    row_hi = (box_y_hi > fh - 1) ? fh - 1 : box_y_hi;
                    span_lo = 0;
                    span_hi = 0;
                    want.span_valid = 1'b0;
                    if (cy >= row_lo && cy <= row_hi) begin
                        // The span starts inverted and each edge on the row widens it.
                        span_lo = box_x_hi;
                        span_hi = box_x_lo;
                        for (int i = 0; i < vert_count; i++) begin
                            nxt = (i + 1 == vert_count) ? 0 : i + 1;
                            ax = vert_x[i];
                            ay = vert_y[i];
                            bx = vert_x[nxt];
                            by = vert_y[nxt];
                            if (by < ay) begin
                                t = ax; ax = bx; bx = t;
                                t = ay; ay = by; by = t;
                            end
                            if (ay <= cy && by >= cy) begin
                                if (by == ay) begin
                                    if (span_lo > ((ax < bx) ? ax : bx)) span_lo = (ax < bx) ? ax : bx;
                                    if (span_hi < ((ax < bx) ? bx : ax)) span_hi = (ax < bx) ? bx : ax;
                                end else begin
                                    hit = cross_at(ax, ay, bx, by, cy);
                                    if (hit < span_lo) span_lo = hit;
                                    if (hit > span_hi) span_hi = hit;
                                end
                            end
                        end
                        if (span_hi >= fw) span_hi = fw - 1;
                        if (span_lo < 0) span_lo = 0;
                        want.span_valid = (span_lo <= span_hi);
                        if (!want.span_valid) begin
                            span_lo = 0;
                            span_hi = 0;
                        end
                    end
                    want.span_row       = y;
                    want.span_start     = span_lo[11:0];
                    want.span_end       = span_hi[11:0];
                    want.vertex_dropped = dropped_flag;
                    expected_spans.push_back(want);
                end
                default: begin
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatch_count++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Called for every accepted result item.
        task check_span(logic [47:0] data, logic [0:0] user);
            t_span_item want;
            if (expected_spans.size() == 0) begin
                report_mismatch("span result arrived with no query waiting");
                return;
            end
            want = expected_spans.pop_front();
            if (user[0] !== want.span_valid)
                report_mismatch($sformatf("row %0d: span_valid %b, expected %b",
                    $signed(want.span_row), user[0], want.span_valid));
            if (data[15:0] !== want.span_row)
                report_mismatch($sformatf("span_row %0d, expected %0d",
                    $signed(data[15:0]), $signed(want.span_row)));
            if (data[27:16] !== want.span_start)
                report_mismatch($sformatf("row %0d: span_start %0d, expected %0d",
                    $signed(want.span_row), data[27:16], want.span_start));
            if (data[39:28] !== want.span_end)
                report_mismatch($sformatf("row %0d: span_end %0d, expected %0d",
                    $signed(want.span_row), data[39:28], want.span_end));
            if (data[40] !== want.vertex_dropped)
                report_mismatch($sformatf("row %0d: vertex_dropped %b, expected %b",
                    $signed(want.span_row), data[40], want.vertex_dropped));
        endtask
    endclass

    t_span_scoreboard sb = new();

    polygon_scanline_span_engine_unit #(
        .MAX_VERTICES(MAX_VERTICES),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side back-pressure.
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            m_axis_tready <= 1'b0;
            out_hold = out_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (out_idle_en && $urandom_range(0, 99) < 20) out_hold = pick_gap();
        end
    end

    // Result checking and the stall watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_span(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("polygon_scanline_span_engine_unit test failed");
                    $finish;
                end
            end
        end
    end

    // Offers one input item, after an optional gap, and waits until it is taken.
    task automatic send_item(input logic [1:0] cmd, input int x, input int y);
        int gap;
        gap = (in_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {16'(y), 16'(x)};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_item(cmd, 16'(x), 16'(y));
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic cfg_write(input logic idx, input logic [12:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        sb.set_frame(idx, val);
    endtask

    // Waits for all spans, then for adds or clears that may still be in work.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_spans.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_coord(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return int'($urandom_range(0, span + 60)) - 30;
        if (r < 85) return int'($urandom_range(0, 4200)) - 50;
        return int'($signed(16'($urandom)));
    endfunction

    // Polygon build-up and queries, with stray and out-of-order items mixed in.
    task automatic run_random(input int n_items, input int x_span, input int y_span);
        int sent, kind, n_vert, n_query, r, px, py, row, y_lo, y_hi;
        sent = 0;
        px = 0;
        py = 0;
        y_lo = 0;
        y_hi = 0;
        while (sent < n_items) begin
            in_idle_en  = ($urandom_range(0, 3) != 0);
            out_idle_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                send_item(2'($urandom), int'(16'($urandom)), int'(16'($urandom)));
                sent++;
            end else begin
                // Most sequences start from a clear polygon; the rest keep adding.
                if (kind >= 15) begin
                    send_item(pss_pkg::CMD_CLEAR, int'(16'($urandom)), int'(16'($urandom)));
                    sent++;
                    y_lo = 32767;
                    y_hi = -32768;
                end
                r = $urandom_range(0, 99);
                if (r < 10) n_vert = $urandom_range(14, 20);
                else if (r < 20) n_vert = $urandom_range(1, 2);
                else n_vert = $urandom_range(3, 8);
                for (int v = 0; v < n_vert; v++) begin
                    px = pick_coord(x_span);
                    // Repeat the last row now and then to get flat edges.
                    if (v == 0 || $urandom_range(0, 99) >= 20) py = pick_coord(y_span);
                    if (py < y_lo) y_lo = py;
                    if (py > y_hi) y_hi = py;
                    send_item(pss_pkg::CMD_ADD, px, py);
                    sent++;
                end
                n_query = $urandom_range(1, 6);
                for (int k = 0; k < n_query; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) row = py;
                    else if (r < 85 && y_lo <= y_hi)
                        row = y_lo - 2 + int'($urandom_range(0, y_hi - y_lo + 4));
                    else row = pick_coord(y_span);
                    send_item(pss_pkg::CMD_QUERY, int'(16'($urandom)), row);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [12:0] fw, input logic [12:0] fh, input int n_items);
        int xs, ys;
        drain_block();
        cfg_write(pss_pkg::REG_FRAME_WIDTH, fw);
        cfg_write(pss_pkg::REG_FRAME_HEIGHT, fh);
        i_cfg_valid <= 1'b0;
        xs = (fw == 0) ? 640 : ((fw > pss_pkg::FRAME_LIMIT) ? pss_pkg::FRAME_LIMIT : fw);
        ys = (fh == 0) ? 480 : ((fh > pss_pkg::FRAME_LIMIT) ? pss_pkg::FRAME_LIMIT : fh);
        run_random(n_items, xs, ys);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = pss_pkg::CMD_CLEAR;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = pss_pkg::REG_FRAME_WIDTH;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items under the reset frame size of 640 x 480.
        send_item(pss_pkg::CMD_QUERY, 0, 0);            // empty polygon
        send_item(CMD_UNUSED, -1, -1);                  // ignored command
        send_item(pss_pkg::CMD_ADD, 100, 50);
        send_item(pss_pkg::CMD_QUERY, 0, 50);           // single vertex closes on itself
        send_item(pss_pkg::CMD_ADD, 300, 50);
        send_item(pss_pkg::CMD_ADD, 200, 250);
        send_item(pss_pkg::CMD_QUERY, 0, 50);           // flat edge on the row
        send_item(pss_pkg::CMD_QUERY, 0, 150);          // two crossings
        send_item(pss_pkg::CMD_QUERY, 0, 250);          // apex
        send_item(pss_pkg::CMD_CLEAR, 0, 0);
        send_item(pss_pkg::CMD_ADD, -100, 10);
        send_item(pss_pkg::CMD_ADD, 1000, 10);
        send_item(pss_pkg::CMD_ADD, 1000, 400);
        send_item(pss_pkg::CMD_ADD, -100, 400);
        send_item(pss_pkg::CMD_QUERY, 0, 200);          // clipped on both sides
        send_item(pss_pkg::CMD_CLEAR, 0, 0);
        send_item(pss_pkg::CMD_ADD, -32768, -32768);
        send_item(pss_pkg::CMD_ADD, 32767, 32767);
        send_item(pss_pkg::CMD_ADD, -32768, 32767);
        send_item(pss_pkg::CMD_QUERY, 0, 0);
        send_item(pss_pkg::CMD_QUERY, 0, 479);
        send_item(pss_pkg::CMD_QUERY, 0, 32767);        // above the frame
        send_item(pss_pkg::CMD_QUERY, 0, -32768);       // below row zero
        send_item(pss_pkg::CMD_CLEAR, 0, 0);
        send_item(pss_pkg::CMD_ADD, 700, 0);
        send_item(pss_pkg::CMD_ADD, 800, 100);
        send_item(pss_pkg::CMD_QUERY, 0, 50);           // span lies right of the frame

        // Random phases over a range of frame sizes, extremes included.
        run_phase(13'd640, 13'd480, 250);
        run_phase(13'd1, 13'd1, 250);
        run_phase(13'd4096, 13'd4096, 250);
        run_phase(13'd8191, 13'd8191, 250);
        run_phase(13'd0, 13'd480, 200);
        run_phase(13'd640, 13'd0, 200);
        run_phase(13'd4097, 13'd100, 250);
        run_phase(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 350);

        drain_block();
        if (sb.mismatch_count == 0) begin
            $display("polygon_scanline_span_engine_unit test passed");
        end else begin
            $display("polygon_scanline_span_engine_unit test failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/pss_pkg.sv
hdl/pss_div.sv
hdl/pss_dp.sv
hdl/pss_ctrl.sv
hdl/polygon_scanline_span_engine_unit.sv
tb/sv/polygon_scanline_span_engine_unit_tb.sv
